### rtl/core/lstk_pkg.sv
package lstk_pkg;

	// operation codes carried on the slave tuser
	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_COUNT  = 3'd3,
		OP_DUMP   = 3'd4,
		OP_SEARCH = 3'd5
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_UNDER    = 2'd1,
		STAT_OVER     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	// field widths
	localparam int unsigned OP_W     = 3;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned NUM_W    = 5;
	localparam int unsigned OUT_W    = 40;

	// a dump emits at most this many words
	localparam int unsigned MAX_RESULTS = 16;

endpackage

### rtl/core/lstk_ram.sv
module lstk_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/lifo_stack_with_search.sv
// lifo stack of signed 32-bit words with search
//
// the slave channel takes one command word a cycle when s_tready is high:
// s_tuser selects the operation (push, pop, peek, count, dump, search) and
// s_tdata carries the word to push or the key to search for. the master
// channel returns result words; m_tlast marks the final result of a command.
// commands with codes six and seven are dropped and give no result.
//
// push and count answer from the accepted command, pop and peek read the top
// entry, search scans bottom first to a match or the end of the fill, and a
// dump sends min(fill, 16) words, one a cycle while the output register is free.
// search and dump read every entry through the single read port of the stack
// memory, and one comparator checks one entry a cycle. a new command is taken
// only once the previous one has put its last result in the output register.
//
// reset empties the stack; memory contents are not cleared. when the master
// side stalls, the output register holds its word and a dump waits; a search
// finishes its scan and then holds its result until the register is free.
module lifo_stack_with_search #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [lstk_pkg::WORD_W-1:0] s_tdata,   // [31:0] operand_value
	input  logic [lstk_pkg::OP_W-1:0]   s_tuser,   // [2:0] operation
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lstk_pkg::OUT_W-1:0]  m_tdata,   // [1:0] status, [33:2] data_out,
	                                               // [38:34] number_out, [39] zero
	output logic                        m_tlast    // last_result
);

	import lstk_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TOP,
		S_DUMP,
		S_SCAN,
		S_RES
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       lim_q;
	logic [AW-1:0]       idx_q;
	logic [WORD_W-1:0]   key_q;
	logic                pop_q;
	status_t             res_status_q;
	logic [NUM_W-1:0]    res_number_q;

	logic                m_tvalid_q;
	status_t             out_status_q;
	logic [WORD_W-1:0]   out_data_q;
	logic [NUM_W-1:0]    out_number_q;
	logic                out_last_q;

	logic                out_free;
	logic                accept;
	logic                empty;
	logic                full;
	logic                at_end;
	logic                match;
	logic [CW-1:0]       pos;
	logic [CW-1:0]       dump_n;
	op_t                 op;

	logic                wr_en;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [WORD_W-1:0]   rd_data;

	// handshake and status of the stack
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);
	assign empty    = (fill_q == '0);
	assign full     = (fill_q == CW'(STACK_DEPTH));
	assign pos      = CW'(idx_q) + CW'(1);
	assign at_end   = (pos == lim_q);
	assign match    = (rd_data == key_q);

	// dump length is capped at the result limit
	always_comb begin
		if (32'(fill_q) > 32'(MAX_RESULTS)) begin
			dump_n = CW'(MAX_RESULTS);
		end else begin
			dump_n = fill_q;
		end
	end

	// memory control
	always_comb begin
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_PUSH: begin
							wr_en = !full;
						end
						OP_POP, OP_PEEK: begin
							rd_en   = !empty;
							rd_addr = AW'(fill_q - CW'(1));
						end
						OP_DUMP, OP_SEARCH: begin
							rd_en = !empty;
						end
						default: begin
							rd_en = 1'b0;
						end
					endcase
				end
			end
			S_DUMP: begin
				rd_en   = out_free && !at_end;
				rd_addr = AW'(pos);
			end
			S_SCAN: begin
				rd_en   = !match && !at_end;
				rd_addr = AW'(pos);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	lstk_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(fill_q)),
		.wr_data (s_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			lim_q        <= '0;
			idx_q        <= '0;
			key_q        <= '0;
			pop_q        <= 1'b0;
			res_status_q <= STAT_OK;
			res_number_q <= '0;
			m_tvalid_q   <= 1'b0;
			out_status_q <= STAT_OK;
			out_data_q   <= '0;
			out_number_q <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						key_q <= s_tdata;
						pop_q <= (op == OP_POP);
						out_data_q   <= '0;
						out_number_q <= '0;
						out_last_q   <= 1'b1;
						out_status_q <= STAT_OK;
						case (op)
							OP_PUSH: begin
								m_tvalid_q <= 1'b1;
								if (full) begin
									out_status_q <= STAT_OVER;
								end else begin
									fill_q <= fill_q + CW'(1);
								end
							end
							OP_POP, OP_PEEK: begin
								if (empty) begin
									m_tvalid_q   <= 1'b1;
									out_status_q <= STAT_UNDER;
								end else begin
									state_q <= S_TOP;
								end
							end
							OP_COUNT: begin
								m_tvalid_q   <= 1'b1;
								out_number_q <= NUM_W'(fill_q);
							end
							OP_DUMP: begin
								lim_q <= dump_n;
								if (empty) begin
									m_tvalid_q <= 1'b1;
								end else begin
									state_q <= S_DUMP;
								end
							end
							OP_SEARCH: begin
								lim_q <= fill_q;
								if (empty) begin
									m_tvalid_q   <= 1'b1;
									out_status_q <= STAT_NOTFOUND;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				// top word is out of the memory
				S_TOP: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= STAT_OK;
						out_data_q   <= rd_data;
						out_number_q <= '0;
						out_last_q   <= 1'b1;
						if (pop_q) begin
							fill_q <= fill_q - CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				// one stored word a cycle while the output register is free, bottom first
				S_DUMP: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= STAT_OK;
						out_data_q   <= rd_data;
						out_number_q <= '0;
						out_last_q   <= at_end;
						if (at_end) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= AW'(pos);
						end
					end
				end
				// compare one entry a cycle against the key
				S_SCAN: begin
					if (match) begin
						res_status_q <= STAT_OK;
						res_number_q <= NUM_W'(pos);
						state_q      <= S_RES;
					end else if (at_end) begin
						res_status_q <= STAT_NOTFOUND;
						res_number_q <= '0;
						state_q      <= S_RES;
					end else begin
						idx_q <= AW'(pos);
					end
				end
				S_RES: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= res_status_q;
						out_data_q   <= '0;
						out_number_q <= res_number_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// master side
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_number_q, out_data_q, out_status_q};
	assign m_tlast  = out_last_q;

endmodule
